@@ sv/cplg_pkg.sv @@
// Shared types, constants and quotient tables for the chassis power limit gain core.
package cplg_pkg;

  localparam int GAIN_FRAC_BITS = 10;
  localparam int OFFLINE_TICKS  = 100;
  localparam int TAP_WINDOW     = 25;

  localparam int GAIN_ONE     = 1 << GAIN_FRAC_BITS;
  localparam int GAIN_W       = GAIN_FRAC_BITS + 2;
  localparam int DRIVE_GAIN_W = 11;
  localparam int GAIN_MAX     = (1 << DRIVE_GAIN_W) - 1;
  localparam int OVF_GAIN_W   = 11;
  localparam int PROD_W       = GAIN_W + OVF_GAIN_W;

  localparam int PCT_W   = 7;
  localparam int BUF_W   = 8;
  localparam int CAP_W   = 8;
  localparam int COUNT_W = 8;
  localparam int TAP_W   = 6;
  localparam int THR_W   = 8;
  localparam int DIFF_W  = 10;
  localparam int MODE_W  = 2;

  localparam int COUNT_CAP = 200;

  localparam int GAIN_TENTH_2 = (2 * GAIN_ONE + 5) / 10;
  localparam int GAIN_TENTH_3 = (3 * GAIN_ONE + 5) / 10;
  localparam int GAIN_TENTH_5 = (5 * GAIN_ONE + 5) / 10;
  localparam int GAIN_TENTH_8 = (8 * GAIN_ONE + 5) / 10;
  localparam int GAIN_BOOST_MAX = GAIN_ONE * 3 / 2;

  localparam int POWER_CAP_LOW = 85;
  localparam int PCT_HIGH      = 60;
  localparam int THR_DROP_HIGH = 10;
  localparam int THR_DROP_LOW  = 5;
  localparam int BASE_BACKUP   = 30;
  localparam int BASE_NORMAL   = 50;
  localparam int BUFFER_BASE   = 30;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Any dividend at or above this many entries lands past every upper bound.
  localparam int QUOT_IDX_W   = 5;
  localparam int QUOT_ENTRIES = 1 << QUOT_IDX_W;

  typedef enum logic {
    REG_BACKUP_MODE   = 1'b0,
    REG_OVERFLOW_GAIN = 1'b1
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    BOOST_NONE   = 2'd0,
    BOOST_SINGLE = 2'd1,
    BOOST_DOUBLE = 2'd2
  } boost_mode_t;

  typedef logic [GAIN_W-1:0] quot_tab_t [QUOT_ENTRIES];

  typedef struct packed {
    logic             boost_key;
    logic             module_msg_seen;
    logic             referee_offline;
    logic [PCT_W-1:0] store_percent;
    logic [BUF_W-1:0] buffer_energy;
    logic [CAP_W-1:0] power_cap;
  } in_item_t;

  typedef struct packed {
    logic [DRIVE_GAIN_W-1:0] drive_gain;
    logic [MODE_W-1:0]       boost_mode;
    logic                    module_offline;
  } out_item_t;

  function automatic quot_tab_t quot_tab_div10();
    quot_tab_t t;
    for (int i = 0; i < QUOT_ENTRIES; i++) begin
      t[i] = GAIN_W'((i * GAIN_ONE) / 10);
    end
    return t;
  endfunction

  function automatic quot_tab_t quot_tab_div13();
    quot_tab_t t;
    for (int i = 0; i < QUOT_ENTRIES; i++) begin
      t[i] = GAIN_W'((i * GAIN_ONE) / 13);
    end
    return t;
  endfunction

  function automatic quot_tab_t quot_tab_div20();
    quot_tab_t t;
    for (int i = 0; i < QUOT_ENTRIES; i++) begin
      t[i] = GAIN_W'((i * GAIN_ONE) / 20);
    end
    return t;
  endfunction

  localparam quot_tab_t QUOT_DIV10 = quot_tab_div10();
  localparam quot_tab_t QUOT_DIV13 = quot_tab_div13();
  localparam quot_tab_t QUOT_DIV20 = quot_tab_div20();

endpackage

@@ sv/chassis_power_limit_gain_core.sv @@
// Top level of the chassis power limit gain core: tick state, gain datapath, APB registers.
// One control tick enters per cycle while in_stall is low, and its result is registered:
// an input register holds the transaction, a single pass of logic (table-based clamped
// quotients and one 12x11 multiplier for the overflow derating) updates the offline counter,
// double-tap detector and boost threshold, and a result register presents the gain. While a
// finished result waits on out_stall, the input register takes at most one more transaction
// and then holds in_stall until the result leaves; with no stall the rate is one
// transaction per clock.
module chassis_power_limit_gain_core
  import cplg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                  backup_mode_r;
  logic [OVF_GAIN_W-1:0] overflow_gain_r;
  logic [COUNT_W-1:0]    offline_count_r, offline_count_nxt;
  logic [TAP_W-1:0]      tap_timer_r, tap_timer_nxt;
  logic                  key_was_pressed_r, key_was_pressed_nxt;
  logic                  release_armed_r, release_armed_nxt;
  logic [THR_W-1:0]      next_threshold_r, next_threshold_nxt;

  logic                  s1_valid_r;
  in_item_t              s1_data_r;
  logic                  out_valid_r;
  out_item_t             out_data_r, out_data_nxt;

  logic                  advance;
  logic                  in_accept;
  logic                  cfg_write;
  cfg_reg_t              cfg_sel;

  assign cfg_sel   = cfg_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    prdata = '0;
    case (cfg_sel)
      REG_BACKUP_MODE:   prdata = CFG_DATA_W'(backup_mode_r);
      REG_OVERFLOW_GAIN: prdata = CFG_DATA_W'(overflow_gain_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backup_mode_r   <= 1'b0;
      overflow_gain_r <= OVF_GAIN_W'(GAIN_ONE);
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_BACKUP_MODE:   backup_mode_r   <= pwdata[0];
        REG_OVERFLOW_GAIN: overflow_gain_r <= pwdata[OVF_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic [COUNT_W-1:0]      cnt_base;
    logic                    mod_off;
    boost_mode_t             mode;
    logic [GAIN_W-1:0]       g_low, g_normal;
    logic [DIFF_W-1:0]       buf_diff, base_diff, thr_diff, sel_diff;
    logic [DIFF_W-1:0]       base;
    logic [GAIN_W-1:0]       sel_lo, sel_hi, quot, clamped;
    logic [QUOT_IDX_W-1:0]   qidx;
    logic                    use13, use20;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-GAIN_FRAC_BITS-1:0] prod_q;
    logic [GAIN_W-1:0]       gain;
    logic [THR_W-1:0]        thr_new;

    cnt_base          = s1_data_r.module_msg_seen ? '0 : offline_count_r;
    offline_count_nxt = (cnt_base < COUNT_W'(COUNT_CAP)) ? cnt_base + 1'b1 : cnt_base;
    mod_off           = offline_count_nxt > COUNT_W'(OFFLINE_TICKS);

    if (s1_data_r.power_cap <= CAP_W'(POWER_CAP_LOW)) begin
      g_low    = GAIN_W'(GAIN_TENTH_3);
      g_normal = GAIN_W'(GAIN_TENTH_5);
    end else begin
      g_low    = GAIN_W'(GAIN_TENTH_5);
      g_normal = GAIN_W'(GAIN_TENTH_8);
    end

    tap_timer_nxt       = tap_timer_r;
    key_was_pressed_nxt = key_was_pressed_r;
    release_armed_nxt   = release_armed_r;
    mode                = BOOST_NONE;
    if (!s1_data_r.boost_key) begin
      if (key_was_pressed_r) begin
        release_armed_nxt = 1'b1;
        if (tap_timer_r == '0) begin
          tap_timer_nxt       = TAP_W'(TAP_WINDOW);
          key_was_pressed_nxt = 1'b0;
          release_armed_nxt   = 1'b0;
        end else begin
          tap_timer_nxt = tap_timer_r - 1'b1;
        end
      end
    end else begin
      key_was_pressed_nxt = 1'b1;
      if (tap_timer_r != '0 && release_armed_r) begin
        tap_timer_nxt = TAP_W'(TAP_WINDOW);
        mode          = BOOST_DOUBLE;
      end else begin
        mode = BOOST_SINGLE;
      end
    end

    base      = backup_mode_r ? DIFF_W'(BASE_BACKUP) : DIFF_W'(BASE_NORMAL);
    buf_diff  = DIFF_W'(s1_data_r.buffer_energy) - DIFF_W'(BUFFER_BASE);
    base_diff = DIFF_W'(s1_data_r.store_percent) - base;
    thr_diff  = DIFF_W'(s1_data_r.store_percent)
              - {{(DIFF_W-THR_W){next_threshold_r[THR_W-1]}}, next_threshold_r};

    use13 = 1'b0;
    use20 = 1'b0;
    if (mod_off) begin
      sel_diff = buf_diff;
      sel_lo   = g_low;
      sel_hi   = g_low + GAIN_W'(GAIN_TENTH_2);
    end else if (mode == BOOST_SINGLE) begin
      sel_diff = base_diff;
      sel_lo   = g_normal;
      sel_hi   = GAIN_W'(GAIN_ONE);
      use20    = 1'b1;
    end else if (mode == BOOST_DOUBLE) begin
      sel_diff = base_diff;
      sel_lo   = g_normal;
      sel_hi   = GAIN_W'(GAIN_BOOST_MAX);
      use13    = 1'b1;
    end else begin
      sel_diff = thr_diff;
      sel_lo   = g_low;
      sel_hi   = g_normal;
    end

    qidx = sel_diff[QUOT_IDX_W-1:0];
    if (use13) begin
      quot = QUOT_DIV13[qidx];
    end else if (use20) begin
      quot = QUOT_DIV20[qidx];
    end else begin
      quot = QUOT_DIV10[qidx];
    end

    if (sel_diff[DIFF_W-1] || sel_diff == '0) begin
      clamped = sel_lo;
    end else if (|sel_diff[DIFF_W-2:QUOT_IDX_W]) begin
      clamped = sel_hi;
    end else if (quot < sel_lo) begin
      clamped = sel_lo;
    end else if (quot > sel_hi) begin
      clamped = sel_hi;
    end else begin
      clamped = quot;
    end

    prod   = PROD_W'(clamped) * PROD_W'(overflow_gain_r);
    prod_q = prod[PROD_W-1:GAIN_FRAC_BITS];

    thr_new = (s1_data_r.store_percent > PCT_W'(PCT_HIGH))
            ? THR_W'(s1_data_r.store_percent) - THR_W'(THR_DROP_HIGH)
            : THR_W'(s1_data_r.store_percent) - THR_W'(THR_DROP_LOW);
    next_threshold_nxt = next_threshold_r;

    if (s1_data_r.referee_offline) begin
      gain = g_low;
    end else if (mod_off) begin
      gain = (prod_q > (PROD_W-GAIN_FRAC_BITS)'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX)
                                                           : GAIN_W'(prod_q);
    end else begin
      gain = clamped;
      if (mode != BOOST_NONE) begin
        next_threshold_nxt = thr_new;
      end
    end

    out_data_nxt.drive_gain     = (gain > GAIN_W'(GAIN_MAX)) ? DRIVE_GAIN_W'(GAIN_MAX)
                                                             : DRIVE_GAIN_W'(gain);
    out_data_nxt.boost_mode     = mode;
    out_data_nxt.module_offline = mod_off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offline_count_r   <= '0;
      tap_timer_r       <= '0;
      key_was_pressed_r <= 1'b0;
      release_armed_r   <= 1'b0;
      next_threshold_r  <= '0;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r       <= 1'b1;
        offline_count_r   <= offline_count_nxt;
        tap_timer_r       <= tap_timer_nxt;
        key_was_pressed_r <= key_was_pressed_nxt;
        release_armed_r   <= release_armed_nxt;
        next_threshold_r  <= next_threshold_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    offline_count_r <= COUNT_W'(COUNT_CAP))
    else $error("offline counter above cap");

  a_armed_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    release_armed_r |-> key_was_pressed_r)
    else $error("release armed without a press");

  a_tap_window: assert property (@(posedge clk) disable iff (!rst_n)
    tap_timer_r <= TAP_W'(TAP_WINDOW))
    else $error("tap timer beyond window");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room downstream");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the chassis power limit gain core, with a predictor and scoreboard.
module tb_top
  import cplg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Q_FRAC     = 10;
  localparam int Q_ONE      = 1024;
  localparam int Q_0P2      = 205;
  localparam int Q_0P3      = 307;
  localparam int Q_0P5      = 512;
  localparam int Q_0P8      = 819;
  localparam int Q_1P5      = 1536;
  localparam int GAIN_CEIL  = 2047;
  localparam int CAP_SPLIT  = 85;
  localparam int OFF_LIMIT  = 100;
  localparam int COUNT_SAT  = 200;
  localparam int TAP_RELOAD = 25;
  localparam int IDLE_PCT   = 22;
  localparam int SETTLE     = 8;
  localparam int MAX_PRINTS = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  in_item_t  tick_q[$];
  out_item_t gain_due_q[$];
  int        mismatch_cnt;
  bit        quiet;
  bit        in_took;

  bit               backup_sel;
  logic [10:0]      derate_gain;
  logic [7:0]       offline_ticks;
  logic [5:0]       tap_left;
  bit               key_latched;
  bit               tap_armed;
  logic signed [7:0] boost_thr;

  chassis_power_limit_gain_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  task automatic report_mismatch(string what, int got, int want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) begin
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    end
  endtask

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic out_item_t tick_outcome(in_item_t t);
    out_item_t   o;
    boost_mode_t m;
    int          lo, nrm, g, k, base, pct;
    bit          off;
    if (t.module_msg_seen) offline_ticks = '0;
    if (offline_ticks < COUNT_SAT) offline_ticks = offline_ticks + 1'b1;
    off = offline_ticks > OFF_LIMIT;
    if (t.power_cap <= CAP_SPLIT) begin
      lo  = Q_0P3;
      nrm = Q_0P5;
    end else begin
      lo  = Q_0P5;
      nrm = Q_0P8;
    end
    if (!t.boost_key) begin
      m = BOOST_NONE;
      if (key_latched) begin
        tap_armed = 1'b1;
        if (tap_left == 0) begin
          tap_left    = 6'(TAP_RELOAD);
          key_latched = 1'b0;
          tap_armed   = 1'b0;
        end else begin
          tap_left = tap_left - 1'b1;
        end
      end
    end else begin
      key_latched = 1'b1;
      if (tap_left > 0 && tap_armed) begin
        tap_left = 6'(TAP_RELOAD);
        m = BOOST_DOUBLE;
      end else begin
        m = BOOST_SINGLE;
      end
    end
    pct = int'(t.store_percent);
    if (t.referee_offline) begin
      g = lo;
    end else if (off) begin
      k = clip((int'(t.buffer_energy) - 30) * Q_ONE / 10, lo, lo + Q_0P2);
      g = (k * int'(derate_gain)) >> Q_FRAC;
    end else if (m != BOOST_NONE) begin
      base = backup_sel ? 30 : 50;
      if (m == BOOST_SINGLE) begin
        g = clip((pct - base) * Q_ONE / 20, nrm, Q_ONE);
      end else begin
        g = clip((pct - base) * Q_ONE / 13, nrm, Q_1P5);
      end
      boost_thr = 8'((pct > 60) ? pct - 10 : pct - 5);
    end else begin
      g = clip((pct - int'(boost_thr)) * Q_ONE / 10, lo, nrm);
    end
    if (g > GAIN_CEIL) g = GAIN_CEIL;
    if (g < 0) g = 0;
    o.drive_gain     = 11'(g);
    o.boost_mode     = m;
    o.module_offline = off;
    return o;
  endfunction

  function automatic in_item_t tick_of(bit key, bit msg, bit rf_off, int pct, int benergy,
                                       int cap);
    in_item_t t;
    t.boost_key       = key;
    t.module_msg_seen = msg;
    t.referee_offline = rf_off;
    t.store_percent   = PCT_W'(pct);
    t.buffer_energy   = BUF_W'(benergy);
    t.power_cap       = CAP_W'(cap);
    return t;
  endfunction

  function automatic in_item_t make_tick(bit key, int rate);
    in_item_t t;
    t.boost_key       = key;
    t.module_msg_seen = $urandom_range(999) < rate;
    t.referee_offline = $urandom_range(9) == 0;
    t.store_percent   = ($urandom_range(4) == 0) ? PCT_W'($urandom_range(127))
                                                 : PCT_W'($urandom_range(100));
    t.buffer_energy   = ($urandom_range(2) == 0) ? BUF_W'($urandom_range(255))
                                                 : BUF_W'($urandom_range(20, 60));
    t.power_cap       = ($urandom_range(1) == 0) ? CAP_W'($urandom_range(255))
                                                 : CAP_W'($urandom_range(80, 90));
    return t;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      if (!in_valid || in_took) begin
        in_took = 1'b0;
        if (tick_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_data  <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      gain_due_q.push_back(tick_outcome(in_data));
      in_took = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (gain_due_q.size() == 0) begin
        report_mismatch("unexpected transaction", int'(out_data), 0);
      end else begin
        want = gain_due_q.pop_front();
        if (out_data.drive_gain !== want.drive_gain)
          report_mismatch("drive_gain", int'(out_data.drive_gain), int'(want.drive_gain));
        if (out_data.boost_mode !== want.boost_mode)
          report_mismatch("boost_mode", int'(out_data.boost_mode), int'(want.boost_mode));
        if (out_data.module_offline !== want.module_offline)
          report_mismatch("module_offline", int'(out_data.module_offline),
                          int'(want.module_offline));
      end
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_BACKUP_MODE) backup_sel = v[0];
    else derate_gain = v[10:0];
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == REG_BACKUP_MODE) begin
      if (rd !== CFG_DATA_W'(backup_sel))
        report_mismatch("backup_mode readback", int'(rd), int'(backup_sel));
    end else if (rd !== CFG_DATA_W'(derate_gain)) begin
      report_mismatch("overflow_gain readback", int'(rd), int'(derate_gain));
    end
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (tick_q.size() != 0 || in_valid || gain_due_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic fill_ticks(int rate, int count);
    int n, kind, a, r, b;
    logic [31:0] w;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(9);
      a = $urandom_range(1, 3);
      b = $urandom_range(1, 3);
      r = (kind < 7) ? $urandom_range(1, 30) : $urandom_range(26, 40);
      if (kind == 9) begin
        repeat (a) begin
          w = $urandom();
          tick_q.push_back(w[$bits(in_item_t)-1:0]);
        end
        n += a;
      end else begin
        repeat (a) tick_q.push_back(make_tick(1'b1, rate));
        repeat (r) tick_q.push_back(make_tick(1'b0, rate));
        repeat (b) tick_q.push_back(make_tick(1'b1, rate));
        repeat (b) tick_q.push_back(make_tick(1'b0, rate));
        n += a + r + 2 * b;
      end
    end
  endtask

  task automatic run_phase(bit bk, int ovf, int rate, bit calm, int count);
    write_reg(REG_BACKUP_MODE, CFG_DATA_W'(bk));
    write_reg(REG_OVERFLOW_GAIN, CFG_DATA_W'(ovf));
    quiet = calm;
    fill_ticks(rate, count);
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatch_cnt  = 0;
    quiet         = 1'b0;
    in_took       = 1'b0;
    backup_sel    = 1'b0;
    derate_gain   = 11'd1024;
    offline_ticks = '0;
    tap_left      = '0;
    key_latched   = 1'b0;
    tap_armed     = 1'b0;
    boost_thr     = '0;

    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b1, 0, 0, 0));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b1, 127, 255, 85));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b1, 0, 0, 86));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b1, 100, 255, 255));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b0, 0, 0, 0));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b0, 127, 0, 255));
    tick_q.push_back(tick_of(1'b1, 1'b1, 1'b0, 127, 0, 0));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b0, 100, 0, 0));
    tick_q.push_back(tick_of(1'b1, 1'b1, 1'b0, 0, 0, 0));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b0, 0, 0, 0));
    tick_q.push_back(tick_of(1'b1, 1'b1, 1'b0, 100, 0, 255));
    tick_q.push_back(tick_of(1'b1, 1'b1, 1'b0, 60, 0, 90));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b0, 61, 0, 90));
    tick_q.push_back(tick_of(1'b1, 1'b1, 1'b0, 61, 0, 90));
    tick_q.push_back(tick_of(1'b1, 1'b1, 1'b0, 50, 0, 90));
    tick_q.push_back(tick_of(1'b0, 1'b1, 1'b0, 127, 255, 255));
    tick_q.push_back(tick_of(1'b0, 1'b0, 1'b0, 55, 128, 170));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();

    run_phase(1'b1, 716, 500, 1'b0, 300);
    run_phase(1'b0, 716, 3, 1'b1, 300);
    run_phase(1'b1, 1024, 20, 1'b0, 300);
    run_phase(1'($urandom_range(1)), $urandom_range(716, 1024), 8, 1'b0, 300);
    run_phase(1'b0, 1024, 100, 1'b0, 300);

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
